// ===== hw/rtl/pvpd_pkg.sv =====
// ---------------------------------------------------------------------------
// pvpd_pkg: shared types and constants of the peak/valley period detector
// Beat layouts of both channels, configuration register indexes, reset
// values and the magnitude helper used by the ratio tests.
// ---------------------------------------------------------------------------
package pvpd_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned INDEX_W  = 32;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned RATIO_W  = 16;
	localparam int unsigned MAG_W    = SAMPLE_W + 1;
	localparam int unsigned PROD_W   = MAG_W + RATIO_W;

	// Configuration register indexes
	localparam logic [1:0] REG_PERIOD_RATIO = 2'd0;
	localparam logic [1:0] REG_TIGHT_RATIO  = 2'd1;
	localparam logic [1:0] REG_PEAK_FLOOR   = 2'd2;

	localparam logic [RATIO_W-1:0]  PERIOD_RATIO_RST = 16'd1792;
	localparam logic [RATIO_W-1:0]  TIGHT_RATIO_RST  = 16'd1254;
	localparam logic [SAMPLE_W-1:0] PEAK_FLOOR_RST   = 16'd0;

	// Input action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	// Result kinds
	localparam logic KIND_MAX = 1'b0;
	localparam logic KIND_MIN = 1'b1;

	// Default depth of the result queue; must be a power of two, at least 2
	localparam int unsigned RESULT_DEPTH = 4;

	typedef struct packed {
		logic                       action;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic                       kind;
		logic [INDEX_W-1:0]         position;
		logic signed [SAMPLE_W-1:0] level;
		logic [PERIOD_W-1:0]        period_number;
		logic                       last;
	} result_t;

	// Absolute value of a signed sample, one bit wider so that -32768 fits.
	function automatic logic [MAG_W-1:0] mag(input logic signed [SAMPLE_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[SAMPLE_W-1], v};
		return v[SAMPLE_W-1] ? MAG_W'(-ext) : ext;
	endfunction

endpackage

// ===== hw/rtl/peak_valley_period_detector.sv =====
// ---------------------------------------------------------------------------
// peak_valley_period_detector: signed sample stream to period extremes
// Tracks the running local maximum and minimum of a sample stream and
// reports both when the ratio tests close a period, and a pending maximum on a flush.
// ---------------------------------------------------------------------------
// Usage
// The item channel carries one beat per sample, or a flush beat (action set)
// that ends the stream. The result channel carries the reported extremes:
// on a closed period a maximum beat then a minimum beat with last set, on a
// flush with a pending maximum a single maximum beat with last set.
// Both channels use valid/ready; a beat moves when both are high.
// An accepted item is registered in the input stage; its results are then
// written into the result queue, from which the receiver takes them.
// Throughput: one item per cycle. The input stage only moves on while the
// result queue has room for two beats (the most one item can produce), so
// a stalled receiver fills the queue and then drops item_ready; nothing is
// lost. The queue depth sets how much stall the block absorbs.
// Reset clears all stream state, loads the register defaults (ratio 7.0,
// tight ratio about 4.9, floor 0) and empties the queue. Registers must be
// written by the user through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module peak_valley_period_detector
	import pvpd_pkg::*;
#(
	parameter int unsigned ResultDepth = RESULT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [RATIO_W-1:0]  cfg_data,

	input  logic                item_valid,
	output logic                item_ready,
	input  item_t               item,

	output logic                result_valid,
	input  logic                result_ready,
	output result_t             result
);

	localparam int unsigned PtrW = (ResultDepth > 1) ? $clog2(ResultDepth) : 1;
	localparam int unsigned CntW = $clog2(ResultDepth + 1);

	// Configuration registers.
	logic [RATIO_W-1:0]         period_ratio_q;
	logic [RATIO_W-1:0]         tight_ratio_q;
	logic signed [SAMPLE_W-1:0] peak_floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ratio_q <= PERIOD_RATIO_RST;
			tight_ratio_q  <= TIGHT_RATIO_RST;
			peak_floor_q   <= PEAK_FLOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD_RATIO: period_ratio_q <= cfg_data;
				REG_TIGHT_RATIO:  tight_ratio_q  <= cfg_data;
				REG_PEAK_FLOOR:   peak_floor_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: the accepted beat is held here until the result queue has room for two beats.
	logic  valid_s1;
	item_t item_s1;
	logic  room2;
	logic  fire;

	assign item_ready = !valid_s1 || room2;
	assign fire       = valid_s1 && room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Stream state.
	logic signed [SAMPLE_W-1:0] older_q, newer_q;
	logic [1:0]                 primed_q;
	logic [INDEX_W-1:0]         count_q;
	logic signed [SAMPLE_W-1:0] low_value_q, high_value_q;
	logic [INDEX_W-1:0]         low_index_q, high_index_q;
	logic                       low_valid_q, high_valid_q;
	logic [PERIOD_W-1:0]        periods_q;

	// Next-state logic for the item in the input stage.
	logic signed [SAMPLE_W-1:0] v, o, n;
	logic [INDEX_W-1:0]         prev_index;
	logic                       primed;
	logic                       low_hit, high_hit;
	logic signed [SAMPLE_W-1:0] low_value_d, high_value_d;
	logic [INDEX_W-1:0]         low_index_d, high_index_d;
	logic                       low_valid_d, high_valid_d;
	logic [PROD_W-1:0]          high_scaled, low_prod, o_prod, n_prod, v_prod;
	logic                       close;
	logic                       flush_emit;
	logic [1:0]                 push;
	result_t                    first_beat, second_beat;

	assign v          = item_s1.sample;
	assign o          = older_q;
	assign n          = newer_q;
	assign prev_index = count_q - INDEX_W'(1);
	assign primed     = (primed_q == 2'd2);

	always_comb begin
		low_hit  = (o >= n) && (n <= v) && (!low_valid_q || n < low_value_q);
		high_hit = (o <= n) && (n >= v) && (n > peak_floor_q)
			&& (!high_valid_q || n > high_value_q);

		// A new maximum clears the minimum, whatever the minimum test found.
		if (high_hit) begin
			low_valid_d = 1'b0;
			low_value_d = '0;
			low_index_d = '0;
		end else if (low_hit) begin
			low_valid_d = 1'b1;
			low_value_d = n;
			low_index_d = prev_index;
		end else begin
			low_valid_d = low_valid_q;
			low_value_d = low_value_q;
			low_index_d = low_index_q;
		end

		if (high_hit) begin
			high_valid_d = 1'b1;
			high_value_d = n;
			high_index_d = prev_index;
		end else begin
			high_valid_d = high_valid_q;
			high_value_d = high_value_q;
			high_index_d = high_index_q;
		end

		// Ratios are Q8.8, so the maximum is scaled by 256 before comparing.
		// Both factors are widened first so that the full product is kept.
		high_scaled = {{(PROD_W-MAG_W-8){1'b0}}, mag(high_value_d), 8'd0};
		low_prod    = PROD_W'(period_ratio_q) * PROD_W'(mag(low_value_d));
		o_prod      = PROD_W'(tight_ratio_q) * PROD_W'(mag(o));
		n_prod      = PROD_W'(tight_ratio_q) * PROD_W'(mag(n));
		v_prod      = PROD_W'(tight_ratio_q) * PROD_W'(mag(v));

		close = primed && high_valid_d && low_valid_d
			&& (high_scaled >= low_prod)
			&& (high_scaled < o_prod) && (high_scaled < n_prod)
			&& (high_scaled < v_prod);

		flush_emit = high_valid_q && (high_value_q > peak_floor_q);

		first_beat.kind          = KIND_MAX;
		first_beat.position      = high_index_d;
		first_beat.level         = high_value_d;
		first_beat.period_number = periods_q;
		first_beat.last          = 1'b0;
		second_beat.kind          = KIND_MIN;
		second_beat.position      = low_index_d;
		second_beat.level         = low_value_d;
		second_beat.period_number = periods_q;
		second_beat.last          = 1'b1;

		push = 2'd0;
		if (fire) begin
			if (item_s1.action == ACT_FLUSH) begin
				// On a flush the pending maximum is the only beat.
				first_beat.position = high_index_q;
				first_beat.level    = high_value_q;
				first_beat.last     = 1'b1;
				push = flush_emit ? 2'd1 : 2'd0;
			end else if (close) begin
				push = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q      <= '0;
			newer_q      <= '0;
			primed_q     <= '0;
			count_q      <= '0;
			low_value_q  <= '0;
			low_index_q  <= '0;
			low_valid_q  <= 1'b0;
			high_value_q <= '0;
			high_index_q <= '0;
			high_valid_q <= 1'b0;
			periods_q    <= '0;
		end else if (fire) begin
			if (item_s1.action == ACT_FLUSH) begin
				older_q      <= '0;
				newer_q      <= '0;
				primed_q     <= '0;
				count_q      <= '0;
				low_value_q  <= '0;
				low_index_q  <= '0;
				low_valid_q  <= 1'b0;
				high_value_q <= '0;
				high_index_q <= '0;
				high_valid_q <= 1'b0;
				periods_q    <= '0;
			end else begin
				older_q <= n;
				newer_q <= v;
				count_q <= count_q + INDEX_W'(1);
				if (!primed) begin
					primed_q <= primed_q + 2'd1;
				end else if (close) begin
					periods_q    <= periods_q + PERIOD_W'(1);
					low_value_q  <= '0;
					low_index_q  <= '0;
					low_valid_q  <= 1'b0;
					high_value_q <= '0;
					high_index_q <= '0;
					high_valid_q <= 1'b0;
				end else begin
					low_value_q  <= low_value_d;
					low_index_q  <= low_index_d;
					low_valid_q  <= low_valid_d;
					high_value_q <= high_value_d;
					high_index_q <= high_index_d;
					high_valid_q <= high_valid_d;
				end
			end
		end
	end

	// Result queue: up to two beats written per cycle, one read.
	result_t         queue_q [ResultDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] fill_q;
	logic            pop;

	assign room2        = (fill_q <= CntW'(ResultDepth - 2));
	assign result_valid = (fill_q != '0);
	assign result       = queue_q[rd_ptr_q];
	assign pop          = result_valid && result_ready;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			queue_q[wr_ptr_q] <= first_beat;
		end
		if (push == 2'd2) begin
			queue_q[wr_ptr_q + PtrW'(1)] <= second_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			fill_q <= fill_q + CntW'(push) - CntW'(pop);
		end
	end

	// Checks on the queue and on the ordering of a closed period.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(ResultDepth))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> fill_q <= CntW'(ResultDepth - 2))
		else $error("input stage moved without room for two beats");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == KIND_MIN) |-> result.last)
		else $error("minimum beat without last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready && !result.last)
		|=> (result_valid && result.kind == KIND_MIN))
		else $error("maximum of a period not followed by its minimum");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.action == ACT_FLUSH) |=> (!high_valid_q && !low_valid_q
			&& primed_q == 2'd0 && count_q == '0))
		else $error("flush did not restart the stream");

endmodule
